// ----- hw/rtl/dslt_pkg.sv -----
// Shared types, constants and helper functions for the dense sigmoid layer trainer.
// Holds the sigmoid lookup table, which is built at elaboration time.
// Depends on nothing; every other file of the block imports it.
package dslt_pkg;

	localparam int IN_MAX_DEF  = 16;
	localparam int OUT_MAX_DEF = 8;
	localparam int FRAC_BITS   = 24;
	localparam int SIG_ENTRIES = 256;
	localparam int SIG_W       = $clog2(SIG_ENTRIES);
	localparam int SIG_SHIFT   = FRAC_BITS + 4 - SIG_W;
	localparam int ACC_W       = 68;

	localparam logic signed [31:0] ONE     = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] HALF    = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic [24:0]        QUARTER = 25'd1 << (FRAC_BITS - 2);

	typedef enum logic [2:0] {
		OP_LOAD  = 3'd0,
		OP_INPUT = 3'd1,
		OP_ERROR = 3'd2,
		OP_APPLY = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		CFG_IN_COUNT   = 2'd0,
		CFG_OUT_COUNT  = 2'd1,
		CFG_LAST_LAYER = 2'd2,
		CFG_LEARN_RATE = 2'd3
	} cfg_reg_t;

	localparam logic KIND_ACT   = 1'b0;
	localparam logic KIND_WREAD = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FWD_RD,
		S_FWD_WAIT,
		S_FWD_ACT,
		S_FWD_DER,
		S_FWD_OUT,
		S_ERR_A,
		S_ERR_B,
		S_ERR_RUN,
		S_UPD,
		S_DRAIN,
		S_RD,
		S_RD_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [4:0]         row;
		logic [2:0]         col;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic               kind;
		logic [2:0]         index;
		logic signed [31:0] result_value;
		logic [24:0]        derivative;
		logic               last;
	} out_item_t;

	typedef logic [SIG_ENTRIES-1:0][FRAC_BITS:0] sig_table_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(64'sh7FFF_FFFF);
		lo = -ACC_W'(64'sh8000_0000);
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Product of two unsigned Q60 values, truncated back to Q60.
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// Restoring long division of unsigned values, used only while the table is built.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, dvs}) begin
				rem    = rem - {1'b0, dvs};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic sig_table_t build_sig_table();
		sig_table_t  tbl;
		logic [63:0] term;
		logic [63:0] q;
		logic [63:0] e;
		logic [63:0] base;
		logic [63:0] den;
		logic [63:0] pos;
		logic [12:0] m;
		int          s;
		term = 64'd1 << 60;
		q    = 64'd1 << 60;
		for (int k = 1; k <= 24; k++) begin
			term = udiv64(term * 64'd8, 64'(SIG_ENTRIES * k));
			if ((k & 1) == 1) begin
				q = q - term;
			end else begin
				q = q + term;
			end
		end
		for (int i = 0; i < SIG_ENTRIES; i++) begin
			s    = 2 * i + 1 - SIG_ENTRIES;
			m    = 13'((s < 0) ? -s : s);
			e    = 64'd1 << 60;
			base = q;
			for (int b = 0; b < 13; b++) begin
				if (m[b]) begin
					e = mul_q60(e, base);
				end
				base = mul_q60(base, base);
			end
			den = ((64'd1 << 60) + e) >> 29;
			pos = udiv64((64'd1 << (31 + FRAC_BITS)) + (den >> 1), den);
			if (s < 0) begin
				pos = (64'd1 << FRAC_BITS) - pos;
			end
			tbl[i] = pos[FRAC_BITS:0];
		end
		return tbl;
	endfunction

	localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

// ----- hw/rtl/dense_sigmoid_layer_trainer.sv -----
// Top level of the dense sigmoid layer trainer: sequencer, weight and change stores,
// the shared multiplier and the result register. Depends on dslt_pkg and dslt_act.
//
//  channel   signals                               direction  handshake
//  command   start, busy, cmd                      in         start && !busy
//  result    result_valid, result                  out        strobe, one cycle
//  config    cfg_valid, cfg_ready, cfg_index,      in         cfg_valid && cfg_ready
//            cfg_data
//
// One 32x32 multiplier, registered, serves every product. A forward pass walks the
// in_count input rows plus the bias row for each neuron. An error element walks the
// same rows through S_ERR_A, S_ERR_B, S_ERR_RUN and S_DRAIN, an apply sweeps all
// (IN_MAX+1)*OUT_MAX weights, and a read keeps the block busy through S_RD and S_RD_OUT,
// its result showing in the cycle after.
// Loads and non-starting input elements finish in the cycle they are accepted.
// Reset is asynchronous and clears control state and the change-store valid bits.
// Results cannot be stalled; each is shown for exactly one cycle.
module dense_sigmoid_layer_trainer import dslt_pkg::*; #(
	parameter int IN_MAX  = IN_MAX_DEF,
	parameter int OUT_MAX = OUT_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    cmd,
	output logic        result_valid,
	output out_item_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int DEPTH  = (IN_MAX + 1) * OUT_MAX;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int RC_W   = $clog2(IN_MAX + 1);
	localparam int IDX_W  = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
	localparam int JW     = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;

	// Configuration registers.
	logic [4:0]  in_count_q;
	logic [3:0]  out_count_q;
	logic        last_layer_q;
	logic [15:0] learn_rate_q;

	// Sequencer state and counters.
	state_t           state_q, state_d;
	in_item_t         item_q;
	logic [RC_W-1:0]  rc_q;
	logic [JW-1:0]    j_q;
	logic [ADDR_W-1:0] ak_q;
	logic             rd_ok_q;
	logic signed [31:0] a_q;

	// Effective counts after clamping.
	int n_eff;
	int m_eff;

	// Stores.
	logic signed [31:0] wmem [DEPTH];
	logic signed [31:0] pmem [DEPTH];
	logic [DEPTH-1:0]   pvalid_q;
	logic signed [31:0] xs_q [IN_MAX];

	// Memory ports.
	logic               w_we;
	logic [ADDR_W-1:0]  w_waddr;
	logic signed [31:0] w_wdata;
	logic [ADDR_W-1:0]  w_raddr;
	logic signed [31:0] w_rdata;
	logic [ADDR_W-1:0]  p_raddr;
	logic signed [31:0] p_rdata;
	logic               pv_s1;

	// Shared multiplier.
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] prod_q;

	// Pipeline tracking.
	logic fwd_issue, err_issue, upd_issue;
	logic fwd_s1, fwd_s2, err_s1, upd_s1;
	logic signed [31:0] x_s1;
	logic [ADDR_W-1:0]  paddr_s1;
	logic signed [ACC_W-1:0] acc_q;

	// Control strobes from the output decoder.
	logic rc_inc, rc_clr, j_inc, ak_inc, acc_clr, act_load, emit_act, emit_rd, a_load;

	logic               accept;
	logic               load_we;
	logic [RC_W-1:0]    row_sel;
	logic signed [31:0] x_sel;
	logic signed [31:0] pend_val;
	logic signed [63:0] t_round;
	logic signed [31:0] act;
	logic [24:0]        der;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_comb begin
		n_eff = int'(in_count_q);
		if (n_eff < 1) begin
			n_eff = 1;
		end else if (n_eff > IN_MAX) begin
			n_eff = IN_MAX;
		end
		m_eff = int'(out_count_q);
		if (m_eff < 1) begin
			m_eff = 1;
		end else if (m_eff > OUT_MAX) begin
			m_eff = OUT_MAX;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q   <= 5'd16;
			out_count_q  <= 4'd8;
			last_layer_q <= 1'b0;
			learn_rate_q <= 16'd252;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IN_COUNT:   in_count_q   <= cfg_data[4:0];
				CFG_OUT_COUNT:  out_count_q  <= cfg_data[3:0];
				CFG_LAST_LAYER: last_layer_q <= cfg_data[0];
				CFG_LEARN_RATE: learn_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The bias row takes the place after the last input row, with an input of one.
	always_comb begin
		if (int'(rc_q) == n_eff) begin
			row_sel = RC_W'(IN_MAX);
			x_sel   = ONE;
		end else begin
			row_sel = rc_q;
			x_sel   = xs_q[IDX_W'(rc_q)];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.op)
						OP_INPUT: begin
							if (int'(cmd.row) < IN_MAX && int'(cmd.row) == n_eff - 1) begin
								state_d = S_FWD_RD;
							end
						end
						OP_ERROR: begin
							if (int'(cmd.col) < m_eff) begin
								state_d = S_ERR_A;
							end
						end
						OP_APPLY: state_d = S_UPD;
						OP_READ:  state_d = S_RD;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_FWD_RD: begin
				if (int'(rc_q) == n_eff) begin
					state_d = S_FWD_WAIT;
				end
			end
			S_FWD_WAIT: begin
				if (!fwd_s1 && !fwd_s2) begin
					state_d = S_FWD_ACT;
				end
			end
			S_FWD_ACT: state_d = S_FWD_DER;
			S_FWD_DER: state_d = S_FWD_OUT;
			S_FWD_OUT: state_d = (int'(j_q) == m_eff - 1) ? S_IDLE : S_FWD_RD;
			S_ERR_A:   state_d = S_ERR_B;
			S_ERR_B:   state_d = S_ERR_RUN;
			S_ERR_RUN: begin
				if (int'(rc_q) == n_eff) begin
					state_d = S_DRAIN;
				end
			end
			S_UPD: begin
				if (ak_q == ADDR_W'(DEPTH - 1)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!err_s1 && !upd_s1) begin
					state_d = S_IDLE;
				end
			end
			S_RD:     state_d = S_RD_OUT;
			S_RD_OUT: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Output decoder: memory addresses, multiplier operands and strobes.
	always_comb begin
		w_raddr   = '0;
		p_raddr   = '0;
		mul_a     = '0;
		mul_b     = '0;
		fwd_issue = 1'b0;
		err_issue = 1'b0;
		upd_issue = 1'b0;
		rc_inc    = 1'b0;
		rc_clr    = 1'b0;
		j_inc     = 1'b0;
		ak_inc    = 1'b0;
		acc_clr   = 1'b0;
		act_load  = 1'b0;
		emit_act  = 1'b0;
		emit_rd   = 1'b0;
		a_load    = 1'b0;
		case (state_q)
			S_IDLE: begin
				rc_clr  = 1'b1;
				acc_clr = 1'b1;
			end
			S_FWD_RD: begin
				w_raddr   = ADDR_W'(int'(row_sel) * OUT_MAX + int'(j_q));
				fwd_issue = 1'b1;
				rc_inc    = 1'b1;
			end
			S_FWD_ACT: act_load = 1'b1;
			S_FWD_DER: begin
				mul_a = act;
				mul_b = ONE - act;
			end
			S_FWD_OUT: begin
				emit_act = 1'b1;
				j_inc    = 1'b1;
				rc_clr   = 1'b1;
				acc_clr  = 1'b1;
			end
			S_ERR_A: begin
				mul_a = 32'(learn_rate_q);
				mul_b = item_q.value;
			end
			S_ERR_B: begin
				a_load = 1'b1;
				rc_clr = 1'b1;
			end
			S_ERR_RUN: begin
				mul_a     = a_q;
				mul_b     = x_sel;
				p_raddr   = ADDR_W'(int'(row_sel) * OUT_MAX + int'(item_q.col));
				err_issue = 1'b1;
				rc_inc    = 1'b1;
			end
			S_UPD: begin
				w_raddr   = ak_q;
				p_raddr   = ak_q;
				upd_issue = 1'b1;
				ak_inc    = 1'b1;
			end
			S_RD: begin
				w_raddr = ADDR_W'(int'(item_q.row) * OUT_MAX + int'(item_q.col));
			end
			S_RD_OUT: emit_rd = 1'b1;
			default: ;
		endcase
		// A weight read in the forward walk is multiplied in the cycle after its issue.
		if (fwd_s1) begin
			mul_a = w_rdata;
			mul_b = x_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rc_q    <= '0;
			j_q     <= '0;
			ak_q    <= '0;
			fwd_s1  <= 1'b0;
			fwd_s2  <= 1'b0;
			err_s1  <= 1'b0;
			upd_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rc_inc) begin
				rc_q <= rc_q + 1'b1;
			end else if (rc_clr) begin
				rc_q <= '0;
			end
			if (j_inc) begin
				j_q <= j_q + 1'b1;
			end else if (state_q == S_IDLE) begin
				j_q <= '0;
			end
			if (ak_inc) begin
				ak_q <= ak_q + 1'b1;
			end else if (state_q == S_IDLE) begin
				ak_q <= '0;
			end
			fwd_s1 <= fwd_issue;
			fwd_s2 <= fwd_s1;
			err_s1 <= err_issue;
			upd_s1 <= upd_issue;
		end
	end

	// Command capture and input element store.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q  <= cmd;
			rd_ok_q <= (int'(cmd.row) <= IN_MAX) && (int'(cmd.col) < OUT_MAX);
			if (cmd.op == OP_INPUT && int'(cmd.row) < IN_MAX) begin
				xs_q[IDX_W'(cmd.row)] <= cmd.value;
			end
		end
	end

	// Shared multiplier and its companions in the pipeline.
	always_ff @(posedge clk) begin
		prod_q   <= mul_a * mul_b;
		x_s1     <= x_sel;
		paddr_s1 <= upd_issue ? ak_q : p_raddr;
		if (a_load) begin
			a_q <= 32'((prod_q + HALF) >>> FRAC_BITS);
		end
		if (acc_clr) begin
			acc_q <= ACC_W'(HALF);
		end else if (fwd_s2) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	// Weight store: loads while idle, sums from the apply sweep otherwise.
	assign load_we  = accept && (cmd.op == OP_LOAD) &&
		(int'(cmd.row) <= IN_MAX) && (int'(cmd.col) < OUT_MAX);
	assign pend_val = pv_s1 ? p_rdata : 32'sd0;
	assign t_round  = (prod_q + HALF) >>> FRAC_BITS;

	always_comb begin
		w_we    = load_we || upd_s1;
		w_waddr = paddr_s1;
		w_wdata = sat32(ACC_W'(w_rdata) + ACC_W'(pend_val));
		if (load_we) begin
			w_waddr = ADDR_W'(int'(cmd.row) * OUT_MAX + int'(cmd.col));
			w_wdata = cmd.value;
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_waddr] <= w_wdata;
		end
		w_rdata <= wmem[w_raddr];
	end

	// Change store. An entry without its valid bit reads as zero.
	always_ff @(posedge clk) begin
		if (err_s1) begin
			pmem[paddr_s1] <= sat32(ACC_W'(pend_val) - ACC_W'(t_round));
		end
		p_rdata <= pmem[p_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= '0;
			pv_s1    <= 1'b0;
		end else begin
			pv_s1 <= pvalid_q[p_raddr];
			if (err_s1) begin
				pvalid_q[paddr_s1] <= 1'b1;
			end else if (upd_s1) begin
				pvalid_q[paddr_s1] <= 1'b0;
			end
		end
	end

	dslt_act u_act (
		.clk    (clk),
		.load   (act_load),
		.bypass (last_layer_q),
		.acc    (acc_q),
		.act    (act)
	);

	assign der = last_layer_q ? 25'(ONE) : 25'(t_round);

	// Result register: one strobe per neuron of a forward pass and one per read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= emit_act || emit_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_act) begin
			result.kind         <= KIND_ACT;
			result.index        <= 3'(j_q);
			result.result_value <= act;
			result.derivative   <= der;
			result.last         <= (int'(j_q) == m_eff - 1);
		end else if (emit_rd) begin
			result.kind         <= KIND_WREAD;
			result.index        <= item_q.col;
			result.result_value <= rd_ok_q ? w_rdata : 32'sd0;
			result.derivative   <= '0;
			result.last         <= 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_drained_before_act: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FWD_ACT |-> !fwd_s1 && !fwd_s2)
		else $error("activation taken before the dot product finished");

	a_idle_pipes_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> !fwd_s1 && !fwd_s2 && !err_s1 && !upd_s1)
		else $error("sequencer went idle with work still in flight");

	a_write_port_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_we |-> !upd_s1)
		else $error("weight load collided with the apply sweep");

	a_read_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_WREAD |-> result.last && !$past(result_valid))
		else $error("weight read result malformed");

	a_der_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_ACT && !last_layer_q |->
			result.derivative <= QUARTER)
		else $error("sigmoid derivative above one quarter");
`endif

endmodule

// ----- hw/rtl/dslt_act.sv -----
// Activation stage: saturates the rounded dot product, sigmoid unless bypassed.
// Depends on dslt_pkg for the table, the fraction width and sat32.
module dslt_act import dslt_pkg::*; (
	input  logic                    clk,
	input  logic                    load,
	input  logic                    bypass,
	input  logic signed [ACC_W-1:0] acc,
	output logic signed [31:0]      act
);

	localparam logic signed [33:0] OFFSET = 34'sd8 <<< FRAC_BITS;

	logic signed [31:0] z;
	logic signed [33:0] u;
	logic signed [33:0] idx_raw;
	logic [SIG_W-1:0]   idx;
	logic signed [31:0] act_q;

	always_comb begin
		z       = sat32(acc >>> FRAC_BITS);
		u       = 34'(z) + OFFSET;
		idx_raw = u >>> SIG_SHIFT;
		if (u <= 34'sd0) begin
			idx = '0;
		end else if (idx_raw > 34'(SIG_ENTRIES - 1)) begin
			idx = SIG_W'(SIG_ENTRIES - 1);
		end else begin
			idx = idx_raw[SIG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			act_q <= bypass ? z : 32'(SIG_TABLE[idx]);
		end
	end

	assign act = act_q;

endmodule
